FILE: hdl/ps2s1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2s1_pkg
// Shared widths, scan code constants and key table lookups for the PS/2
// scan code set 1 decoder.
// ----------------------------------------------------------------------------
package ps2s1_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MAKE_W = 7;

  localparam logic [BYTE_W-1:0] BYTE_E0 = 8'hE0;
  localparam logic [BYTE_W-1:0] BYTE_E1 = 8'hE1;
  localparam logic [BYTE_W-1:0] BYTE_2A = 8'h2A;
  localparam logic [BYTE_W-1:0] BYTE_B7 = 8'hB7;
  localparam logic [BYTE_W-1:0] BYTE_37 = 8'h37;
  localparam logic [BYTE_W-1:0] BYTE_AA = 8'hAA;
  localparam logic [BYTE_W-1:0] BYTE_1D = 8'h1D;
  localparam logic [BYTE_W-1:0] BYTE_45 = 8'h45;
  localparam logic [BYTE_W-1:0] BYTE_9D = 8'h9D;
  localparam logic [BYTE_W-1:0] BYTE_C5 = 8'hC5;

  localparam logic [BYTE_W-1:0] KEY_PRINT = 8'hB7;
  localparam logic [BYTE_W-1:0] KEY_PAUSE = 8'hC5;

  // base key table: make codes 01..53, 56, 57, 58
  function automatic logic base_known(input logic [MAKE_W-1:0] mk);
    logic hit;
    hit = (mk inside {[7'h01:7'h53], 7'h56, 7'h57, 7'h58});
    return hit;
  endfunction

  // extended (e0) key table
  function automatic logic ext_known(input logic [MAKE_W-1:0] mk);
    logic hit;
    hit = (mk inside {7'h1C, 7'h1D, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49, 7'h4B,
                      7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h5B, 7'h5C,
                      7'h5D});
    return hit;
  endfunction

endpackage

FILE: hdl/ps2s1_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2s1 channel interfaces
// Valid/ready channels for scan bytes in and key events out.
// ----------------------------------------------------------------------------
interface ps2s1_byte_if;
  logic                          valid;
  logic                          ready;
  logic [ps2s1_pkg::BYTE_W-1:0]  scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2s1_key_if;
  logic                          valid;
  logic                          ready;
  logic [ps2s1_pkg::BYTE_W-1:0]  key_code;
  logic                          released;

  modport source (output valid, output key_code, output released, input ready);
  modport sink   (input valid, input key_code, input released, output ready);
endinterface

FILE: hdl/ps2_set1_scancode_decoder.sv
`timescale 1ns / 1ps
// result: an event is decoded from the input register into the result register
// throughput: one scan byte per cycle while the result register is free or the
//   byte makes no event, set by the single decode stage between the registers
// reset: synchronous active-low rst_n empties both registers and returns the
//   sequence state to base
// ----------------------------------------------------------------------------
// ps2_set1_scancode_decoder
// Decodes scan code set 1 bytes, including the e0 prefix and the print screen
// and pause sequences, into key press and release events.
// ----------------------------------------------------------------------------
module ps2_set1_scancode_decoder (
  input  logic              clk,
  input  logic              rst_n,
  ps2s1_byte_if.sink        in_chan,
  ps2s1_key_if.source       out_chan
);

  typedef enum logic [3:0] {
    ST_BASE      = 4'd0,
    ST_E0        = 4'd1,
    ST_PRT_MK_E0 = 4'd2,
    ST_PRT_MK_37 = 4'd3,
    ST_PRT_BK_E0 = 4'd4,
    ST_PRT_BK_AA = 4'd5,
    ST_PAU_1D    = 4'd6,
    ST_PAU_45    = 4'd7,
    ST_PAU_E1    = 4'd8,
    ST_PAU_9D    = 4'd9,
    ST_PAU_C5    = 4'd10
  } seq_state_t;

  seq_state_t                    state_r, state_nxt;
  logic                          in_v_r;
  logic [ps2s1_pkg::BYTE_W-1:0]  byte_r;
  logic                          out_v_r;
  logic [ps2s1_pkg::BYTE_W-1:0]  code_r;
  logic                          rel_r;

  logic [ps2s1_pkg::MAKE_W-1:0]  mk;
  seq_state_t                    base_st;
  logic                          base_hit;
  logic                          hit;
  logic [ps2s1_pkg::BYTE_W-1:0]  code;
  logic                          rel;
  logic                          out_free;
  logic                          consume;

  // byte handled as a base byte
  always_comb begin
    mk       = byte_r[ps2s1_pkg::MAKE_W-1:0];
    base_hit = 1'b0;
    if (byte_r == ps2s1_pkg::BYTE_E0) begin
      base_st = ST_E0;
    end else if (byte_r == ps2s1_pkg::BYTE_E1) begin
      base_st = ST_PAU_1D;
    end else begin
      base_st  = ST_BASE;
      base_hit = ps2s1_pkg::base_known(mk);
    end
  end

  always_comb begin
    state_nxt = base_st;
    hit       = base_hit;
    code      = {1'b0, mk};
    rel       = byte_r[ps2s1_pkg::BYTE_W-1];
    case (state_r)
      ST_BASE: begin
      end
      ST_E0: begin
        hit  = 1'b0;
        code = {1'b1, mk};
        if (byte_r == ps2s1_pkg::BYTE_2A) begin
          state_nxt = ST_PRT_MK_E0;
        end else if (byte_r == ps2s1_pkg::BYTE_B7) begin
          state_nxt = ST_PRT_BK_E0;
        end else begin
          state_nxt = ST_BASE;
          hit       = ps2s1_pkg::ext_known(mk);
        end
      end
      ST_PRT_MK_E0: begin
        if (byte_r == ps2s1_pkg::BYTE_E0) begin
          state_nxt = ST_PRT_MK_37;
          hit       = 1'b0;
        end
      end
      ST_PRT_MK_37: begin
        if (byte_r == ps2s1_pkg::BYTE_37) begin
          state_nxt = ST_BASE;
          hit       = 1'b1;
          code      = ps2s1_pkg::KEY_PRINT;
          rel       = 1'b0;
        end
      end
      ST_PRT_BK_E0: begin
        if (byte_r == ps2s1_pkg::BYTE_E0) begin
          state_nxt = ST_PRT_BK_AA;
          hit       = 1'b0;
        end
      end
      ST_PRT_BK_AA: begin
        if (byte_r == ps2s1_pkg::BYTE_AA) begin
          state_nxt = ST_BASE;
          hit       = 1'b1;
          code      = ps2s1_pkg::KEY_PRINT;
          rel       = 1'b1;
        end
      end
      ST_PAU_1D: begin
        if (byte_r == ps2s1_pkg::BYTE_1D) begin
          state_nxt = ST_PAU_45;
          hit       = 1'b0;
        end
      end
      ST_PAU_45: begin
        if (byte_r == ps2s1_pkg::BYTE_45) begin
          state_nxt = ST_PAU_E1;
          hit       = 1'b0;
        end
      end
      ST_PAU_E1: begin
        if (byte_r == ps2s1_pkg::BYTE_E1) begin
          state_nxt = ST_PAU_9D;
          hit       = 1'b0;
        end
      end
      ST_PAU_9D: begin
        if (byte_r == ps2s1_pkg::BYTE_9D) begin
          state_nxt = ST_PAU_C5;
          hit       = 1'b0;
        end
      end
      ST_PAU_C5: begin
        if (byte_r == ps2s1_pkg::BYTE_C5) begin
          state_nxt = ST_BASE;
          hit       = 1'b1;
          code      = ps2s1_pkg::KEY_PAUSE;
          rel       = 1'b0;
        end
      end
      default: begin
        // unreachable encoding: drop the byte
        state_nxt = ST_BASE;
        hit       = 1'b0;
      end
    endcase
  end

  // a byte with no event never waits for the result register
  assign out_free      = !out_v_r || out_chan.ready;
  assign consume       = in_v_r && (!hit || out_free);
  assign in_chan.ready = !in_v_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BASE;
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_v_r <= in_chan.valid;
        byte_r <= in_chan.scan_byte;
      end
      if (consume) begin
        state_r <= state_nxt;
      end
      if (consume && hit) begin
        out_v_r <= 1'b1;
        code_r  <= code;
        rel_r   <= rel;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.key_code = code_r;
  assign out_chan.released = rel_r;

endmodule

FILE: hdl/ps2s1_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2s1_checker
// Port-level checks for the scan code decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2s1_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ps2s1_pkg::BYTE_W-1:0]  key_code,
  input  logic                          released
);

  // no event right after reset
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a stalled event is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // pause has no release event
  a_pause_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && key_code == ps2s1_pkg::KEY_PAUSE |-> !released)
    else $error("pause reported as released");

  // base keys never use code zero
  a_base_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !key_code[ps2s1_pkg::BYTE_W-1] |-> key_code != '0)
    else $error("base key with code zero");

endmodule

bind ps2_set1_scancode_decoder ps2s1_checker u_ps2s1_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .key_code  (out_chan.key_code),
  .released  (out_chan.released)
);

FILE: bench/tb_ps2_set1_scancode_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_set1_scancode_decoder
// Feeds scan code set 1 byte streams (plain keys, e0 keys, print screen and
// pause sequences, broken sequences and noise) into the decoder under random
// idle and stall patterns, and checks every key event in order against a
// local copy of the sequence tracker.
// ----------------------------------------------------------------------------
module tb_ps2_set1_scancode_decoder;

  localparam int ITEMS       = 1850;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 4;
  localparam logic [ps2s1_pkg::BYTE_W-1:0] NO_KEY = 8'h00;

  typedef enum logic [3:0] {
    SEQ_BASE, SEQ_E0, SEQ_PRT_MK_E0, SEQ_PRT_MK_37, SEQ_PRT_BK_E0, SEQ_PRT_BK_AA,
    SEQ_PAU_1D, SEQ_PAU_45, SEQ_PAU_E1, SEQ_PAU_9D, SEQ_PAU_C5
  } seq_state_t;

  typedef struct packed {
    logic [ps2s1_pkg::BYTE_W-1:0] key_code;
    logic                         released;
  } key_evt_t;

  typedef struct packed {
    logic [ps2s1_pkg::BYTE_W-1:0] scan_byte;
    logic                         typed;
    logic                         has_key;
    logic [ps2s1_pkg::BYTE_W-1:0] key_code;
    logic                         released;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ps2s1_byte_if in_if ();
  ps2s1_key_if  out_if ();

  ps2_set1_scancode_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  seq_state_t seq_q;
  key_evt_t   pending_keys [$];
  dir_row_t   dir_rows [26];
  int         fails;
  int         items_sent;
  int         cycle_cnt;
  int         src_idle;
  int         sink_stall;

  always #5 clk = ~clk;

  function automatic logic is_base_key(input logic [ps2s1_pkg::MAKE_W-1:0] mk);
    return (mk >= 7'h01 && mk <= 7'h53) || mk == 7'h56 || mk == 7'h57 || mk == 7'h58;
  endfunction

  function automatic logic is_ext_key(input logic [ps2s1_pkg::MAKE_W-1:0] mk);
    case (mk)
      7'h1C, 7'h1D, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D,
      7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h5B, 7'h5C, 7'h5D: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // byte seen from the base state, also used when a sequence breaks
  function automatic logic decode_plain(input logic [ps2s1_pkg::BYTE_W-1:0] b,
                                        output key_evt_t ev);
    logic hit;
    hit = 1'b0;
    ev  = '0;
    if (b == ps2s1_pkg::BYTE_E0) begin
      seq_q = SEQ_E0;
    end else if (b == ps2s1_pkg::BYTE_E1) begin
      seq_q = SEQ_PAU_1D;
    end else begin
      seq_q = SEQ_BASE;
      if (is_base_key(b[ps2s1_pkg::MAKE_W-1:0])) begin
        hit = 1'b1;
        ev  = {1'b0, b[ps2s1_pkg::MAKE_W-1:0], b[7]};
      end
    end
    return hit;
  endfunction

  function automatic logic decode_byte(input logic [ps2s1_pkg::BYTE_W-1:0] b,
                                       output key_evt_t ev);
    logic hit;
    hit = 1'b0;
    ev  = '0;
    case (seq_q)
      SEQ_BASE: hit = decode_plain(b, ev);
      SEQ_E0: begin
        if (b == ps2s1_pkg::BYTE_2A) begin
          seq_q = SEQ_PRT_MK_E0;
        end else if (b == ps2s1_pkg::BYTE_B7) begin
          seq_q = SEQ_PRT_BK_E0;
        end else begin
          seq_q = SEQ_BASE;
          if (is_ext_key(b[ps2s1_pkg::MAKE_W-1:0])) begin
            hit = 1'b1;
            ev  = {1'b1, b[ps2s1_pkg::MAKE_W-1:0], b[7]};
          end
        end
      end
      SEQ_PRT_MK_E0: begin
        if (b == ps2s1_pkg::BYTE_E0) seq_q = SEQ_PRT_MK_37;
        else hit = decode_plain(b, ev);
      end
      SEQ_PRT_MK_37: begin
        if (b == ps2s1_pkg::BYTE_37) begin
          seq_q = SEQ_BASE;
          hit   = 1'b1;
          ev    = {ps2s1_pkg::KEY_PRINT, 1'b0};
        end else begin
          hit = decode_plain(b, ev);
        end
      end
      SEQ_PRT_BK_E0: begin
        if (b == ps2s1_pkg::BYTE_E0) seq_q = SEQ_PRT_BK_AA;
        else hit = decode_plain(b, ev);
      end
      SEQ_PRT_BK_AA: begin
        if (b == ps2s1_pkg::BYTE_AA) begin
          seq_q = SEQ_BASE;
          hit   = 1'b1;
          ev    = {ps2s1_pkg::KEY_PRINT, 1'b1};
        end else begin
          hit = decode_plain(b, ev);
        end
      end
      SEQ_PAU_1D: begin
        if (b == ps2s1_pkg::BYTE_1D) seq_q = SEQ_PAU_45;
        else hit = decode_plain(b, ev);
      end
      SEQ_PAU_45: begin
        if (b == ps2s1_pkg::BYTE_45) seq_q = SEQ_PAU_E1;
        else hit = decode_plain(b, ev);
      end
      SEQ_PAU_E1: begin
        if (b == ps2s1_pkg::BYTE_E1) seq_q = SEQ_PAU_9D;
        else hit = decode_plain(b, ev);
      end
      SEQ_PAU_9D: begin
        if (b == ps2s1_pkg::BYTE_9D) seq_q = SEQ_PAU_C5;
        else hit = decode_plain(b, ev);
      end
      SEQ_PAU_C5: begin
        if (b == ps2s1_pkg::BYTE_C5) begin
          seq_q = SEQ_BASE;
          hit   = 1'b1;
          ev    = {ps2s1_pkg::KEY_PAUSE, 1'b0};
        end else begin
          hit = decode_plain(b, ev);
        end
      end
      default: seq_q = SEQ_BASE;
    endcase
    return hit;
  endfunction

  task automatic send_byte(input logic [ps2s1_pkg::BYTE_W-1:0] b, input logic typed,
                           input logic t_hit, input key_evt_t t_ev);
    logic     acc;
    logic     hit;
    key_evt_t ev;
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.scan_byte <= b;
    do begin
      @(negedge clk);
      acc = in_if.ready;
      @(posedge clk);
    end while (!acc);
    hit = decode_byte(b, ev);
    if (typed) begin
      hit = t_hit;
      ev  = t_ev;
    end
    if (hit) pending_keys.push_back(ev);
    items_sent++;
  endtask

  // one plain byte, one e0 key, or a full or broken multi-byte sequence
  task automatic send_burst();
    logic [ps2s1_pkg::BYTE_W-1:0] seq_bytes [6];
    logic [ps2s1_pkg::MAKE_W-1:0] mk;
    int                           kind;
    int                           n;
    int                           cut;
    kind = $urandom_range(0, 99);
    seq_bytes = '{default: '0};
    if (kind < 30) begin
      if ($urandom_range(0, 1)) begin
        do mk = 7'($urandom_range(0, 127)); while (!is_base_key(mk));
        seq_bytes[0] = {1'($urandom_range(0, 1)), mk};
      end else begin
        seq_bytes[0] = 8'($urandom_range(0, 255));
      end
      n = 1;
    end else if (kind < 55) begin
      seq_bytes[0] = ps2s1_pkg::BYTE_E0;
      if ($urandom_range(0, 9) < 7) begin
        do mk = 7'($urandom_range(0, 127)); while (!is_ext_key(mk));
        seq_bytes[1] = {1'($urandom_range(0, 1)), mk};
      end else begin
        seq_bytes[1] = 8'($urandom_range(0, 255));
      end
      n = 2;
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          seq_bytes = '{ps2s1_pkg::BYTE_E0, ps2s1_pkg::BYTE_2A, ps2s1_pkg::BYTE_E0,
                        ps2s1_pkg::BYTE_37, NO_KEY, NO_KEY};
          n = 4;
        end
        1: begin
          seq_bytes = '{ps2s1_pkg::BYTE_E0, ps2s1_pkg::BYTE_B7, ps2s1_pkg::BYTE_E0,
                        ps2s1_pkg::BYTE_AA, NO_KEY, NO_KEY};
          n = 4;
        end
        default: begin
          seq_bytes = '{ps2s1_pkg::BYTE_E1, ps2s1_pkg::BYTE_1D, ps2s1_pkg::BYTE_45,
                        ps2s1_pkg::BYTE_E1, ps2s1_pkg::BYTE_9D, ps2s1_pkg::BYTE_C5};
          n = 6;
        end
      endcase
      if (kind >= 80) begin
        cut = $urandom_range(1, n - 1);
        case ($urandom_range(0, 3))
          0:       seq_bytes[cut] = ps2s1_pkg::BYTE_E0;
          1:       seq_bytes[cut] = ps2s1_pkg::BYTE_E1;
          default: seq_bytes[cut] = 8'($urandom_range(0, 255));
        endcase
        n = cut + 1;
      end
    end
    for (int i = 0; i < n; i++) send_byte(seq_bytes[i], 1'b0, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= sink_stall);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin : key_check
    key_evt_t exp_ev;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_keys.size() == 0) begin
        $error("unexpected key event key_code=%h released=%b",
               out_if.key_code, out_if.released);
        fails++;
      end else begin
        exp_ev = pending_keys.pop_front();
        if (out_if.key_code !== exp_ev.key_code) begin
          $error("key_code expected %h actual %h", exp_ev.key_code, out_if.key_code);
          fails++;
        end
        if (out_if.released !== exp_ev.released) begin
          $error("released expected %b actual %b", exp_ev.released, out_if.released);
          fails++;
        end
      end
    end
  end

  initial begin
    int phase;
    int next_switch;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.scan_byte = '0;
    out_if.ready    = 1'b0;
    seq_q           = SEQ_BASE;
    fails           = 0;
    items_sent      = 0;
    cycle_cnt       = 0;
    src_idle        = 0;
    sink_stall      = 0;
    dir_rows = '{
      {8'h00,              1'b1, 1'b0, NO_KEY,               1'b0},
      {8'h01,              1'b1, 1'b1, 8'h01,                1'b0},
      {8'h81,              1'b1, 1'b1, 8'h01,                1'b1},
      {8'hFF,              1'b1, 1'b0, NO_KEY,               1'b0},
      {8'h58,              1'b1, 1'b1, 8'h58,                1'b0},
      {8'h54,              1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_E0, 1'b1, 1'b0, NO_KEY,               1'b0},
      {8'h1C,              1'b1, 1'b1, 8'h9C,                1'b0},
      {ps2s1_pkg::BYTE_E0, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_E0, 1'b0, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_E0, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_2A, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_E0, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_37, 1'b1, 1'b1, ps2s1_pkg::KEY_PRINT, 1'b0},
      {ps2s1_pkg::BYTE_E0, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_B7, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_E0, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_AA, 1'b1, 1'b1, ps2s1_pkg::KEY_PRINT, 1'b1},
      {ps2s1_pkg::BYTE_E1, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_1D, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_45, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_E1, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_9D, 1'b1, 1'b0, NO_KEY,               1'b0},
      {ps2s1_pkg::BYTE_C5, 1'b1, 1'b1, ps2s1_pkg::KEY_PAUSE, 1'b0},
      {ps2s1_pkg::BYTE_E1, 1'b1, 1'b0, NO_KEY,               1'b0},
      {8'h9E,              1'b0, 1'b0, NO_KEY,               1'b0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, no idling
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].scan_byte, dir_rows[i].typed, dir_rows[i].has_key,
                {dir_rows[i].key_code, dir_rows[i].released});
    end

    phase       = 0;
    next_switch = items_sent + PHASE_ITEMS;
    while (items_sent < ITEMS) begin
      if (items_sent >= next_switch) begin
        phase       = (phase + 1) % 4;
        next_switch = items_sent + PHASE_ITEMS;
        case (phase)
          1:       begin src_idle = 83; sink_stall = 0;  end
          2:       begin src_idle = 0;  sink_stall = 83; end
          3:       begin src_idle = 24; sink_stall = 24; end
          default: begin src_idle = 0;  sink_stall = 0;  end
        endcase
      end
      send_burst();
    end

    in_if.valid <= 1'b0;
    sink_stall  = 0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
